// ===== hdl/twvs_pkg.sv =====
// shared constants for the time-weighted value statistics block
`default_nettype none

package twvs_pkg;

    // default sizes of the watched value and of the tick clock
    localparam int unsigned VALUE_BITS_DEF = 16;
    localparam int unsigned TIME_BITS_DEF  = 32;

    // fixed widths of the running sums and the change counter
    localparam int unsigned SUM_W   = 64;
    localparam int unsigned COUNT_W = 32;

    // squaring works on magnitudes below 2^40, the square is taken >> 16
    localparam int unsigned SQ_OPERAND_BITS = 40;
    localparam int unsigned SQ_SHIFT        = 16;
    localparam int unsigned SQ_PRODUCT_BITS = 2 * SQ_OPERAND_BITS;

    // transaction kinds
    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_REPORT = 2'd1;
    localparam logic [1:0] FUNC_RESET  = 2'd2;

    // saturation limits of the 64-bit sums
    localparam logic [SUM_W-1:0] SUM_MAX_S = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN_S = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_ONES  = {SUM_W{1'b1}};

endpackage

`default_nettype wire

// ===== hdl/time_weighted_value_stats.sv =====
// top level of the time-weighted value statistics block
//
//  channel | direction | ports                                          | handshake
//  --------+-----------+------------------------------------------------+------------------
//  s_      | in        | s_func, s_item_time, s_new_value               | s_valid / s_ready
//  m_      | out       | m_changed, m_current_value, m_change_count,    | m_valid / m_ready
//          |           | m_average, m_squares_total, m_min_value,       |
//          |           | m_max_value                                    |
//
// the wide arithmetic steps run through one shared add/subtract unit, so each
// multiply is shift-add over its multiplier bits and the divide is restoring
// reset, unused kinds and samples with no change go straight to the result
// changing sample: weighted product, then the square (skipped when it saturates)
// report: the total ticks, then as a changing sample, then the divide unless no ticks have passed
// aresetn is synchronous, active low, and clears the statistics at once
// s_ready is high only between transactions; a finished result waits in the
// output register, so a stalled m_ready holds only the next result back
`default_nettype none

module time_weighted_value_stats
    import twvs_pkg::*;
#(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
    parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic [TIME_BITS-1:0]         s_item_time,
    input  logic signed [VALUE_BITS-1:0] s_new_value,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_changed,
    output logic signed [VALUE_BITS-1:0] m_current_value,
    output logic [COUNT_W-1:0]           m_change_count,
    output logic signed [VALUE_BITS-1:0] m_average,
    output logic [SUM_W-1:0]             m_squares_total,
    output logic signed [VALUE_BITS-1:0] m_min_value,
    output logic signed [VALUE_BITS-1:0] m_max_value
);

    // datapath width: full value*ticks product or the 80-bit square
    localparam int unsigned AW  = (VALUE_BITS + TIME_BITS > SQ_PRODUCT_BITS) ?
                                  (VALUE_BITS + TIME_BITS) : SQ_PRODUCT_BITS;
    // multiplier register holds |value| or the 40-bit square operand
    localparam int unsigned MPW = (VALUE_BITS > SQ_OPERAND_BITS) ?
                                  VALUE_BITS : SQ_OPERAND_BITS;
    localparam int unsigned CNT_W = $clog2(MPW + 1);

    localparam logic [CNT_W-1:0] PROD_STEPS = CNT_W'(VALUE_BITS);
    localparam logic [CNT_W-1:0] SQ_STEPS   = CNT_W'(SQ_OPERAND_BITS);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(VALUE_BITS);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // sequencer states
    localparam int unsigned ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] ST_TOTAL  = 4'd1;   // ticks since start
    localparam logic [ST_W-1:0] ST_DT     = 4'd2;   // ticks since last change
    localparam logic [ST_W-1:0] ST_MUL    = 4'd3;   // one shift-add step
    localparam logic [ST_W-1:0] ST_MULEND = 4'd4;
    localparam logic [ST_W-1:0] ST_WADD   = 4'd5;   // weighted sum update
    localparam logic [ST_W-1:0] ST_SADD   = 4'd6;   // sum of squares update
    localparam logic [ST_W-1:0] ST_ABS    = 4'd7;   // magnitude of weighted sum
    localparam logic [ST_W-1:0] ST_DIV    = 4'd8;   // one restoring divide step
    localparam logic [ST_W-1:0] ST_AVG    = 4'd9;
    localparam logic [ST_W-1:0] ST_DONE   = 4'd10;

    // sequencer and item registers
    logic [ST_W-1:0]              state_reg, state_next;
    logic [1:0]                   func_reg, func_next;
    logic [TIME_BITS-1:0]         now_reg, now_next;
    logic signed [VALUE_BITS-1:0] nv_reg, nv_next;

    // working registers
    logic [SUM_W-1:0]             ws_work_reg, ws_work_next;
    logic [SUM_W-1:0]             sq_work_reg, sq_work_next;
    logic [TIME_BITS-1:0]         total_reg, total_next;
    logic [AW-1:0]                mcand_reg, mcand_next;
    logic [MPW-1:0]               mplier_reg, mplier_next;
    logic [AW-1:0]                acc_reg, acc_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         sq_mode_reg, sq_mode_next;
    logic [SUM_W-1:0]             mag_reg, mag_next;
    logic [SUM_W-1:0]             sq_term_reg, sq_term_next;
    logic [SUM_W-1:0]             rem_reg, rem_next;
    logic [AW-1:0]                div_d_reg, div_d_next;
    logic [VALUE_BITS-1:0]        q_reg, q_next;
    logic signed [VALUE_BITS-1:0] avg_reg, avg_next;

    // statistics state
    logic signed [VALUE_BITS-1:0] held_reg, held_next;
    logic [COUNT_W-1:0]           changes_reg, changes_next;
    logic [SUM_W-1:0]             wsum_reg, wsum_next;
    logic [SUM_W-1:0]             ssum_reg, ssum_next;
    logic signed [VALUE_BITS-1:0] lowest_reg, lowest_next;
    logic signed [VALUE_BITS-1:0] highest_reg, highest_next;
    logic [TIME_BITS-1:0]         start_reg, start_next;
    logic [TIME_BITS-1:0]         last_reg, last_next;

    // result register
    logic                         m_valid_reg, m_valid_next;
    logic                         out_changed_reg, out_changed_next;
    logic signed [VALUE_BITS-1:0] out_current_reg, out_current_next;
    logic [COUNT_W-1:0]           out_count_reg, out_count_next;
    logic signed [VALUE_BITS-1:0] out_avg_reg, out_avg_next;
    logic [SUM_W-1:0]             out_sq_reg, out_sq_next;
    logic signed [VALUE_BITS-1:0] out_min_reg, out_min_next;
    logic signed [VALUE_BITS-1:0] out_max_reg, out_max_next;

    // shared unit hookup
    logic [AW-1:0] alu_a, alu_b, alu_sum;
    logic          alu_sub, alu_carry;

    // magnitude of the held value, most negative value maps to 2^(VALUE_BITS-1)
    logic [VALUE_BITS-1:0] held_bits, abs_held;
    logic [AW-SUM_W:0]     ws_top;

    assign held_bits = held_reg;
    assign abs_held  = held_bits[VALUE_BITS-1] ? (~held_bits + VALUE_BITS'(1)) : held_bits;
    // upper bits of the weighted sum add, equal everywhere when no overflow
    assign ws_top    = alu_sum[AW-1:SUM_W-1];

    twvs_addsub #(
        .WIDTH (AW)
    ) u_addsub (
        .a_in  (alu_a),
        .b_in  (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        func_next        = func_reg;
        now_next         = now_reg;
        nv_next          = nv_reg;
        ws_work_next     = ws_work_reg;
        sq_work_next     = sq_work_reg;
        total_next       = total_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        acc_next         = acc_reg;
        cnt_next         = cnt_reg;
        sq_mode_next     = sq_mode_reg;
        mag_next         = mag_reg;
        sq_term_next     = sq_term_reg;
        rem_next         = rem_reg;
        div_d_next       = div_d_reg;
        q_next           = q_reg;
        avg_next         = avg_reg;
        held_next        = held_reg;
        changes_next     = changes_reg;
        wsum_next        = wsum_reg;
        ssum_next        = ssum_reg;
        lowest_next      = lowest_reg;
        highest_next     = highest_reg;
        start_next       = start_reg;
        last_next        = last_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_changed_next = out_changed_reg;
        out_current_next = out_current_reg;
        out_count_next   = out_count_reg;
        out_avg_next     = out_avg_reg;
        out_sq_next      = out_sq_reg;
        out_min_next     = out_min_reg;
        out_max_next     = out_max_reg;
        alu_a            = '0;
        alu_b            = '0;
        alu_sub          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next    = s_func;
                    now_next     = s_item_time;
                    nv_next      = s_new_value;
                    ws_work_next = wsum_reg;
                    sq_work_next = ssum_reg;
                    avg_next     = '0;
                    case (s_func)
                        FUNC_SAMPLE: begin
                            // only a new value closes a segment
                            state_next = (s_new_value != held_reg) ? ST_DT : ST_DONE;
                        end
                        FUNC_REPORT: begin
                            state_next = ST_TOTAL;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_TOTAL: begin
                // time running backwards counts as zero ticks
                alu_a      = AW'(now_reg);
                alu_b      = AW'(start_reg);
                alu_sub    = 1'b1;
                total_next = alu_carry ? alu_sum[TIME_BITS-1:0] : '0;
                state_next = ST_DT;
            end

            ST_DT: begin
                alu_a        = AW'(now_reg);
                alu_b        = AW'(last_reg);
                alu_sub      = 1'b1;
                mcand_next   = alu_carry ? AW'(alu_sum[TIME_BITS-1:0]) : '0;
                mplier_next  = MPW'(abs_held);
                acc_next     = '0;
                cnt_next     = PROD_STEPS;
                sq_mode_next = 1'b0;
                state_next   = ST_MUL;
            end

            ST_MUL: begin
                alu_a       = acc_reg;
                alu_b       = mplier_reg[0] ? mcand_reg : '0;
                acc_next    = alu_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE) begin
                    state_next = ST_MULEND;
                end
            end

            ST_MULEND: begin
                if (sq_mode_reg) begin
                    sq_term_next = acc_reg[SQ_SHIFT +: SUM_W];
                    state_next   = ST_SADD;
                end else begin
                    // product magnitude clamps to the largest positive sum
                    mag_next   = (|acc_reg[AW-1:SUM_W-1]) ? SUM_MAX_S : acc_reg[SUM_W-1:0];
                    state_next = ST_WADD;
                end
            end

            ST_WADD: begin
                // signed add of +/- magnitude, clamped to the 64-bit range
                alu_a   = AW'(signed'(ws_work_reg));
                alu_b   = AW'(mag_reg);
                alu_sub = held_bits[VALUE_BITS-1];
                if ((&ws_top) || !(|ws_top)) begin
                    ws_work_next = alu_sum[SUM_W-1:0];
                end else begin
                    ws_work_next = alu_sum[AW-1] ? SUM_MIN_S : SUM_MAX_S;
                end
                if (|mag_reg[SUM_W-1:SQ_OPERAND_BITS]) begin
                    // square would not fit in 64 bits
                    sq_term_next = SUM_ONES;
                    state_next   = ST_SADD;
                end else begin
                    mcand_next   = AW'(mag_reg);
                    mplier_next  = MPW'(mag_reg[SQ_OPERAND_BITS-1:0]);
                    acc_next     = '0;
                    cnt_next     = SQ_STEPS;
                    sq_mode_next = 1'b1;
                    state_next   = ST_MUL;
                end
            end

            ST_SADD: begin
                alu_a        = AW'(sq_work_reg);
                alu_b        = AW'(sq_term_reg);
                sq_work_next = alu_sum[SUM_W] ? SUM_ONES : alu_sum[SUM_W-1:0];
                if (func_reg == FUNC_REPORT) begin
                    // no elapsed time leaves the average at zero
                    state_next = (total_reg == '0) ? ST_DONE : ST_ABS;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_ABS: begin
                alu_a      = '0;
                alu_b      = AW'(signed'(ws_work_reg));
                alu_sub    = ws_work_reg[SUM_W-1];
                rem_next   = alu_sum[SUM_W-1:0];
                // first step tests the quotient against 2^(VALUE_BITS-1)
                div_d_next = AW'(total_reg) << (VALUE_BITS - 1);
                cnt_next   = DIV_STEPS;
                q_next     = '0;
                state_next = ST_DIV;
            end

            ST_DIV: begin
                alu_a   = AW'(rem_reg);
                alu_b   = div_d_reg;
                alu_sub = 1'b1;
                if (alu_carry) begin
                    rem_next = alu_sum[SUM_W-1:0];
                end
                q_next     = {q_reg[VALUE_BITS-2:0], alu_carry};
                div_d_next = div_d_reg >> 1;
                cnt_next   = cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE) begin
                    state_next = ST_AVG;
                end
            end

            ST_AVG: begin
                // quotient truncates toward zero, top bit set means overflow
                if (q_reg[VALUE_BITS-1]) begin
                    avg_next = ws_work_reg[SUM_W-1] ? VAL_MIN : VAL_MAX;
                end else begin
                    avg_next = ws_work_reg[SUM_W-1] ? (~q_reg + VALUE_BITS'(1)) : q_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    case (func_reg)
                        FUNC_RESET: begin
                            held_next    = '0;
                            changes_next = '0;
                            wsum_next    = '0;
                            ssum_next    = '0;
                            lowest_next  = VAL_MAX;
                            highest_next = VAL_MIN;
                            start_next   = now_reg;
                            last_next    = now_reg;
                        end
                        FUNC_SAMPLE: begin
                            if (nv_reg != held_reg) begin
                                held_next    = nv_reg;
                                last_next    = now_reg;
                                changes_next = (&changes_reg) ? changes_reg :
                                               (changes_reg + COUNT_W'(1));
                                wsum_next    = ws_work_reg;
                                ssum_next    = sq_work_reg;
                                if (nv_reg < lowest_reg) begin
                                    lowest_next = nv_reg;
                                end
                                if (nv_reg > highest_reg) begin
                                    highest_next = nv_reg;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    // report shows the closing segment without storing it
                    m_valid_next     = 1'b1;
                    out_changed_next = (func_reg == FUNC_SAMPLE) && (nv_reg != held_reg);
                    out_current_next = held_next;
                    out_count_next   = changes_next;
                    out_avg_next     = avg_reg;
                    out_sq_next      = (func_reg == FUNC_REPORT) ? sq_work_reg : ssum_next;
                    out_min_next     = lowest_next;
                    out_max_next     = highest_next;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            held_reg    <= '0;
            changes_reg <= '0;
            wsum_reg    <= '0;
            ssum_reg    <= '0;
            lowest_reg  <= VAL_MAX;
            highest_reg <= VAL_MIN;
            start_reg   <= '0;
            last_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            held_reg    <= held_next;
            changes_reg <= changes_next;
            wsum_reg    <= wsum_next;
            ssum_reg    <= ssum_next;
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
            start_reg   <= start_next;
            last_reg    <= last_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        func_reg        <= func_next;
        now_reg         <= now_next;
        nv_reg          <= nv_next;
        ws_work_reg     <= ws_work_next;
        sq_work_reg     <= sq_work_next;
        total_reg       <= total_next;
        mcand_reg       <= mcand_next;
        mplier_reg      <= mplier_next;
        acc_reg         <= acc_next;
        cnt_reg         <= cnt_next;
        sq_mode_reg     <= sq_mode_next;
        mag_reg         <= mag_next;
        sq_term_reg     <= sq_term_next;
        rem_reg         <= rem_next;
        div_d_reg       <= div_d_next;
        q_reg           <= q_next;
        avg_reg         <= avg_next;
        out_changed_reg <= out_changed_next;
        out_current_reg <= out_current_next;
        out_count_reg   <= out_count_next;
        out_avg_reg     <= out_avg_next;
        out_sq_reg      <= out_sq_next;
        out_min_reg     <= out_min_next;
        out_max_reg     <= out_max_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_changed       = out_changed_reg;
    assign m_current_value = out_current_reg;
    assign m_change_count  = out_count_reg;
    assign m_average       = out_avg_reg;
    assign m_squares_total = out_sq_reg;
    assign m_min_value     = out_min_reg;
    assign m_max_value     = out_max_reg;

endmodule

`default_nettype wire

// ===== hdl/twvs_addsub.sv =====
// shared wide adder and subtractor of the statistics sequencer
`default_nettype none

module twvs_addsub
    import twvs_pkg::*;
#(
    parameter int unsigned WIDTH = SQ_PRODUCT_BITS
) (
    input  logic [WIDTH-1:0] a_in,
    input  logic [WIDTH-1:0] b_in,
    input  logic             sub,
    output logic [WIDTH-1:0] sum,
    output logic             carry
);

    logic [WIDTH:0] full;

    // carry high on subtract means a_in >= b_in
    assign full  = {1'b0, a_in} + {1'b0, (sub ? ~b_in : b_in)} + {{WIDTH{1'b0}}, sub};
    assign sum   = full[WIDTH-1:0];
    assign carry = full[WIDTH];

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the time-weighted value statistics block
`default_nettype none

module tb
    import twvs_pkg::*;
();

    localparam int unsigned VW = VALUE_BITS_DEF;
    localparam int unsigned TW = TIME_BITS_DEF;

    // the one transaction kind the package leaves unnamed
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [SUM_W-1:0] AVG_LIMIT = (64'd1 << (VW - 1)) - 64'd1;
    localparam logic [TW-1:0] TIME_TOP = {TW{1'b1}};

    localparam int RANDOM_ITEMS = 1625;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 2 * VW + 120;

    // one result transaction
    typedef struct {
        logic                 changed;
        logic signed [VW-1:0] current;
        logic [COUNT_W-1:0]   count;
        logic signed [VW-1:0] avg;
        logic [SUM_W-1:0]     squares;
        logic signed [VW-1:0] lowest;
        logic signed [VW-1:0] highest;
    } stats_t;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct {
        logic [1:0]           func;
        logic [TW-1:0]        at;
        logic signed [VW-1:0] value;
        bit                   typed;
        stats_t               want;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_func = FUNC_SAMPLE;
    logic [TW-1:0]        s_item_time = '0;
    logic signed [VW-1:0] s_new_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_changed;
    logic signed [VW-1:0] m_current_value;
    logic [COUNT_W-1:0]   m_change_count;
    logic signed [VW-1:0] m_average;
    logic [SUM_W-1:0]     m_squares_total;
    logic signed [VW-1:0] m_min_value;
    logic signed [VW-1:0] m_max_value;

    time_weighted_value_stats #(
        .VALUE_BITS(VW),
        .TIME_BITS (TW)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_item_time    (s_item_time),
        .s_new_value    (s_new_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_changed      (m_changed),
        .m_current_value(m_current_value),
        .m_change_count (m_change_count),
        .m_average      (m_average),
        .m_squares_total(m_squares_total),
        .m_min_value    (m_min_value),
        .m_max_value    (m_max_value)
    );

    // expected results in order of acceptance
    stats_t pending_stats[$];
    int     errors = 0;
    int     counted_items = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     hold_asks = 0;

    // watch state mirrored from the block
    logic signed [VW-1:0] held_value;
    logic [COUNT_W-1:0]   change_total;
    logic [SUM_W-1:0]     weighted_total;
    logic [SUM_W-1:0]     square_total;
    logic signed [VW-1:0] lowest_seen;
    logic signed [VW-1:0] highest_seen;
    logic [TW-1:0]        watch_start;
    logic [TW-1:0]        last_change;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the handshake hangs
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [SUM_W-1:0] ticks_between(logic [TW-1:0] now, logic [TW-1:0] then_t);
        return (now >= then_t) ? SUM_W'(now - then_t) : '0;
    endfunction

    // (mag * mag) >> 16, all ones once the operand leaves the squarer range
    function automatic logic [SUM_W-1:0] square_term(logic [SUM_W-1:0] mag);
        logic [2*SUM_W-1:0] full;
        if (mag >= (64'd1 << SQ_OPERAND_BITS))
            return SUM_ONES;
        full = {64'd0, mag} * {64'd0, mag};
        return full[SQ_SHIFT +: SUM_W];
    endfunction

    // fold value v held for dt ticks into a weighted sum and a sum of squares
    task automatic fold_segment(input logic signed [VW-1:0] v, input logic [SUM_W-1:0] dt,
                                inout logic [SUM_W-1:0] wsum, inout logic [SUM_W-1:0] ssum);
        logic signed [VW:0]   wide;
        logic [SUM_W-1:0]     mag;
        logic [2*SUM_W-1:0]   full;
        logic signed [SUM_W+1:0] term;
        logic signed [SUM_W+1:0] acc;
        logic [SUM_W:0]       usum;
        wide = v;
        mag = '0;
        mag[VW:0] = wide[VW] ? -wide : wide;
        full = {64'd0, mag} * {64'd0, dt};
        // product magnitude saturates to the signed 64-bit maximum
        mag = (full > {64'd0, SUM_MAX_S}) ? SUM_MAX_S : full[SUM_W-1:0];
        term = $signed({2'b00, mag});
        if (wide[VW])
            term = -term;
        acc = $signed({{2{wsum[SUM_W-1]}}, wsum}) + term;
        if (acc[SUM_W+1:SUM_W-1] != 3'b000 && acc[SUM_W+1:SUM_W-1] != 3'b111)
            wsum = acc[SUM_W+1] ? SUM_MIN_S : SUM_MAX_S;
        else
            wsum = acc[SUM_W-1:0];
        usum = {1'b0, ssum} + {1'b0, square_term(mag)};
        ssum = usum[SUM_W] ? SUM_ONES : usum[SUM_W-1:0];
    endtask

    task automatic clear_watch(input logic [TW-1:0] at);
        held_value     = '0;
        change_total   = '0;
        weighted_total = '0;
        square_total   = '0;
        lowest_seen    = VAL_MAX;
        highest_seen   = VAL_MIN;
        watch_start    = at;
        last_change    = at;
    endtask

    // advance the mirrored state by one transaction and give its result
    task automatic predict_stats(input logic [1:0] func, input logic [TW-1:0] now,
                                 input logic signed [VW-1:0] nv, output stats_t r);
        logic [SUM_W-1:0] ws;
        logic [SUM_W-1:0] sq;
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] quot;
        r.changed = 1'b0;
        r.avg = '0;
        if (func == FUNC_RESET) begin
            clear_watch(now);
        end else if (func == FUNC_SAMPLE && nv != held_value) begin
            fold_segment(held_value, ticks_between(now, last_change), weighted_total,
                         square_total);
            last_change = now;
            held_value = nv;
            r.changed = 1'b1;
            if (change_total != {COUNT_W{1'b1}})
                change_total = change_total + 1'b1;
            if (lowest_seen > nv)
                lowest_seen = nv;
            if (highest_seen < nv)
                highest_seen = nv;
        end
        sq = square_total;
        if (func == FUNC_REPORT) begin
            // closing segment goes into copies only
            ws = weighted_total;
            total = ticks_between(now, watch_start);
            fold_segment(held_value, ticks_between(now, last_change), ws, sq);
            if (total != 0) begin
                mag = ws[SUM_W-1] ? (64'd0 - ws) : ws;
                quot = mag / total;
                if (quot > AVG_LIMIT)
                    r.avg = ws[SUM_W-1] ? VAL_MIN : VAL_MAX;
                else
                    r.avg = ws[SUM_W-1] ? -quot[VW-1:0] : quot[VW-1:0];
            end
        end
        r.current = held_value;
        r.count   = change_total;
        r.squares = sq;
        r.lowest  = lowest_seen;
        r.highest = highest_seen;
    endtask

    // offer one transaction, wait for acceptance, then record its expectation
    task automatic offer(input logic [1:0] func, input logic [TW-1:0] at,
                         input logic signed [VW-1:0] value, input bit typed, input stats_t want);
        stats_t predicted;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_item_time <= at;
        s_new_value <= value;
        do @(posedge aclk); while (!s_ready);
        predict_stats(func, at, value, predicted);
        pending_stats.push_back(typed ? want : predicted);
        counted_items++;
    endtask

    // stop sending until every expected result has come back
    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_stats.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // result side: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        stats_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_stats.size() == 0) begin
                errors++;
                $display("%0t: result transaction with nothing expected, current %0h",
                         $time, m_current_value);
            end else begin
                want = pending_stats.pop_front();
                check_field("changed", want.changed, m_changed);
                check_field("current_value", want.current, m_current_value);
                check_field("change_count", want.count, m_change_count);
                check_field("average", want.avg, m_average);
                check_field("squares_total", want.squares, m_squares_total);
                check_field("min_value", want.lowest, m_min_value);
                check_field("max_value", want.highest, m_max_value);
            end
        end
    end

    // receiver: random stalls plus a long hold-off when asked for one
    initial begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin : stimulus
        dir_row_t             rows[$];
        stats_t               fresh;
        logic [TW-1:0]        t;
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] pool[4];
        logic [1:0]           kind;
        int                   len;
        int                   pick;
        bit                   hold_done;

        hold_done = 0;
        t = '0;
        fresh = '{1'b0, '0, '0, '0, '0, VAL_MAX, VAL_MIN};
        clear_watch('0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; after reset the block shows the fresh statistics
        rows.push_back('{FUNC_REPORT, 32'd0, 16'sd0, 1'b1, fresh});
        rows.push_back('{FUNC_UNUSED, 32'd5, 16'sh5A5A, 1'b1, fresh});
        rows.push_back('{FUNC_RESET, 32'd100, -16'sd1, 1'b1, fresh});
        rows.push_back('{FUNC_SAMPLE, 32'd110, 16'sd0, 1'b1, fresh});
        rows.push_back('{FUNC_SAMPLE, 32'd200, VAL_MAX, 1'b1,
                         '{1'b1, VAL_MAX, 32'd1, 16'sd0, 64'd0, VAL_MAX, VAL_MAX}});
        rows.push_back('{FUNC_SAMPLE, 32'd300, VAL_MIN, 1'b0, fresh});
        rows.push_back('{FUNC_REPORT, 32'd400, 16'sd0, 1'b0, fresh});
        rows.push_back('{FUNC_SAMPLE, 32'd500, VAL_MIN, 1'b0, fresh});
        // most negative value held for nearly the whole tick range saturates the square
        rows.push_back('{FUNC_SAMPLE, TIME_TOP, 16'sd1, 1'b1,
                         '{1'b1, 16'sd1, 32'd3, 16'sd0, SUM_ONES, VAL_MIN, VAL_MAX}});
        rows.push_back('{FUNC_REPORT, TIME_TOP, 16'sd0, 1'b0, fresh});
        // time running backwards makes the average overflow upward
        rows.push_back('{FUNC_RESET, 32'd1000, 16'sd0, 1'b1, fresh});
        rows.push_back('{FUNC_SAMPLE, 32'd1000, 16'sd20000, 1'b0, fresh});
        rows.push_back('{FUNC_SAMPLE, 32'd9000, -16'sd5, 1'b0, fresh});
        rows.push_back('{FUNC_SAMPLE, 32'd1010, 16'sd7, 1'b0, fresh});
        rows.push_back('{FUNC_REPORT, 32'd1002, 16'sd0, 1'b0, fresh});
        // and downward
        rows.push_back('{FUNC_RESET, 32'd2000, 16'sd0, 1'b1, fresh});
        rows.push_back('{FUNC_SAMPLE, 32'd2000, -16'sd20000, 1'b0, fresh});
        rows.push_back('{FUNC_SAMPLE, 32'd12000, 16'sd3, 1'b0, fresh});
        rows.push_back('{FUNC_SAMPLE, 32'd2001, 16'sd4, 1'b0, fresh});
        rows.push_back('{FUNC_REPORT, 32'd2001, 16'sd0, 1'b0, fresh});
        // report before the watch started: no ticks, average zero
        rows.push_back('{FUNC_RESET, 32'd5000, 16'sd0, 1'b1, fresh});
        rows.push_back('{FUNC_REPORT, 32'd4000, 16'sd0, 1'b1, fresh});
        rows.push_back('{FUNC_SAMPLE, 32'd4500, VAL_MAX, 1'b0, fresh});
        rows.push_back('{FUNC_UNUSED, TIME_TOP, -16'sd1, 1'b0, fresh});
        rows.push_back('{FUNC_REPORT, TIME_TOP, VAL_MIN, 1'b0, fresh});

        foreach (rows[i])
            offer(rows[i].func, rows[i].at, rows[i].value, rows[i].typed, rows[i].want);
        wait_all_results();

        // random part in four idling phases
        counted_items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct = 62;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 62;
                end
                default: begin
                    idle_pct = 23;
                    stall_pct <= 23;
                end
            endcase
            while (counted_items < RANDOM_ITEMS * (ph + 1) / 4) begin
                // a watch session: usually opened by a reset, closed by a report
                pick = $urandom_range(5);
                if (pick == 0)
                    t = TIME_TOP - TW'($urandom_range(0, 1 << 16));
                else if (pick == 1)
                    t = TW'($urandom);
                else
                    t = TW'($urandom_range(0, 1 << 20));
                if ($urandom_range(11) != 0)
                    offer(FUNC_RESET, t, VW'($urandom), 1'b0, fresh);
                foreach (pool[k])
                    pool[k] = VW'($urandom);
                len = $urandom_range(3, 40);
                repeat (len) begin
                    pick = $urandom_range(19);
                    if (pick == 1)
                        t = t + TW'($urandom_range(0, 1 << 26));
                    else if (pick == 2)
                        t = t - TW'($urandom_range(0, 200));
                    else if (pick > 2)
                        t = t + TW'($urandom_range(1, 64));
                    pick = $urandom_range(9);
                    if (pick < 4)
                        v = pool[$urandom_range(3)];
                    else if (pick < 8)
                        v = VW'($urandom);
                    else if (pick == 8)
                        v = $urandom_range(1) ? VAL_MAX : VAL_MIN;
                    else
                        v = VW'($urandom_range(0, 511)) - VW'(256);
                    pick = $urandom_range(99);
                    if (pick < 84)
                        kind = FUNC_SAMPLE;
                    else if (pick < 94)
                        kind = FUNC_REPORT;
                    else if (pick < 97)
                        kind = FUNC_UNUSED;
                    else
                        kind = FUNC_RESET;
                    offer(kind, t, v, 1'b0, fresh);
                    // long receiver hold-off once, while transactions keep coming
                    if (ph == 0 && !hold_done && counted_items >= 40) begin
                        hold_asks <= hold_asks + 1;
                        hold_done = 1;
                    end
                end
                offer(FUNC_REPORT, t, VW'($urandom), 1'b0, fresh);
                if ($urandom_range(9) == 0)
                    wait_all_results();
            end
            wait_all_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
